FILE: hw/rtl/lbrs_pkg.sv
`default_nettype none

package lbrs_pkg;

  localparam int LBRS_MAX_ENTRIES = 64;
  localparam int LBRS_VALUE_BITS  = 31;

  localparam int LBRS_VAL_W   = 31;
  localparam int LBRS_MOVES_W = 12;

  typedef struct packed {
    logic [LBRS_VAL_W-1:0] value;
    logic                  last;
  } lbrs_in_t;

  typedef struct packed {
    logic [LBRS_VAL_W-1:0]   sorted_value;
    logic                    last_out;
    logic [LBRS_MOVES_W-1:0] move_count;
  } lbrs_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lbrs_bank.sv
`default_nettype none

module lbrs_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 31,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lsd_binary_radix_sort.sv
// Channel  Ports                         Handshake
// request  start, busy, in_data          taken when start && !busy
// result   out_strobe, out_data          one cycle per result, cannot stall
//
// Loading takes one cycle per request. A request with last starts the sort:
// L passes, L the bit length of the largest value, each pass two scans over
// the n entries through one read and one write port.
// The two banks swap roles after every pass.
// rst_n is synchronous; the banks hold no reset, only entries below the
// count are read. busy stays high from the sort start until the last result.
`default_nettype none

module lsd_binary_radix_sort
  import lbrs_pkg::*;
#(
  parameter int MAX_ENTRIES = LBRS_MAX_ENTRIES,
  parameter int VALUE_BITS  = LBRS_VALUE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire lbrs_in_t  in_data,
  output logic           out_strobe,
  output lbrs_out_t      out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [VALUE_BITS-1:0] max_r, max_nxt;
  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [PW-1:0]         pass_r, pass_nxt;
  logic                  phase_r, phase_nxt;
  logic                  src_r, src_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic [CW-1:0]         wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]         nz_r, nz_nxt;
  logic [LBRS_MOVES_W-1:0] tally_r, tally_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  lbrs_out_t             out_r, out_nxt;

  logic                  accept;
  logic [VALUE_BITS-1:0] in_val;
  logic                  w_en;
  logic                  w_bank;
  logic [AW-1:0]         w_addr;
  logic [VALUE_BITS-1:0] w_data;
  logic [VALUE_BITS-1:0] rdata0, rdata1, rd;
  logic                  bit_v;

  assign accept = start && !busy;
  assign in_val = in_data.value[VALUE_BITS-1:0];
  assign rd     = src_r ? rdata1 : rdata0;
  assign bit_v  = rd[pass_r];

  lbrs_bank #(.DEPTH(MAX_ENTRIES), .WIDTH(VALUE_BITS), .AW(AW)) u_bank0 (
    .clk   (clk),
    .we    (w_en && !w_bank),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata0)
  );

  lbrs_bank #(.DEPTH(MAX_ENTRIES), .WIDTH(VALUE_BITS), .AW(AW)) u_bank1 (
    .clk   (clk),
    .we    (w_en && w_bank),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata1)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    max_nxt        = max_r;
    sh_nxt         = sh_r;
    pass_nxt       = pass_r;
    phase_nxt      = phase_r;
    src_nxt        = src_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    nz_nxt         = nz_r;
    tally_nxt      = tally_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    w_en           = 1'b0;
    w_bank         = src_r;
    w_addr         = count_r[AW-1:0];
    w_data         = in_val;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (count_r < CW'(MAX_ENTRIES)) begin
            w_en      = 1'b1;
            count_nxt = count_r + 1'b1;
            if (in_val > max_r) begin
              max_nxt = in_val;
            end
          end
          if (in_data.last) begin
            sh_nxt     = max_nxt;
            pass_nxt   = '0;
            phase_nxt  = 1'b0;
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
            nz_nxt     = '0;
            tally_nxt  = '0;
            state_nxt  = (max_nxt == '0) ? S_EMIT : S_PASS;
          end
        end
      end

      S_PASS: begin
        if (rd_idx_r < count_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          w_bank = !src_r;
          w_addr = wr_idx_r[AW-1:0];
          w_data = rd;
          if (bit_v == phase_r) begin
            w_en       = 1'b1;
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
          if (!phase_r && !bit_v) begin
            nz_nxt = nz_r + 1'b1;
          end
        end
        if (rd_idx_r == count_r && !rd_vld_r) begin
          rd_idx_nxt = '0;
          rd_vld_nxt = 1'b0;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt  = 1'b0;
            tally_nxt  = tally_r + LBRS_MOVES_W'(count_r) + LBRS_MOVES_W'(nz_r);
            src_nxt    = !src_r;
            pass_nxt   = pass_r + 1'b1;
            sh_nxt     = sh_r >> 1;
            wr_idx_nxt = '0;
            nz_nxt     = '0;
            if ((sh_r >> 1) == '0) begin
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_EMIT: begin
        if (rd_idx_r < count_r) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (CW'(rd_idx_r + 1'b1) == count_r);
        end
        if (rd_vld_r) begin
          out_strobe_nxt       = 1'b1;
          out_nxt.sorted_value = LBRS_VAL_W'(rd);
          out_nxt.last_out     = rd_last_r;
          out_nxt.move_count   = tally_r;
          if (rd_last_r) begin
            count_nxt  = '0;
            max_nxt    = '0;
            tally_nxt  = '0;
            rd_idx_nxt = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      max_r        <= '0;
      sh_r         <= '0;
      pass_r       <= '0;
      phase_r      <= 1'b0;
      src_r        <= 1'b0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      wr_idx_r     <= '0;
      nz_r         <= '0;
      tally_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      max_r        <= max_nxt;
      sh_r         <= sh_nxt;
      pass_r       <= pass_nxt;
      phase_r      <= phase_nxt;
      src_r        <= src_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_last_r    <= rd_last_nxt;
      wr_idx_r     <= wr_idx_nxt;
      nz_r         <= nz_nxt;
      tally_r      <= tally_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r) == S_EMIT)
    else $error("result strobe outside emission");

  a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.last_out |-> state_r == S_IDLE)
    else $error("sequencer not idle after final result");

  a_wr_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PASS |-> wr_idx_r <= count_r && nz_r <= count_r)
    else $error("partition write index past entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count past store depth");
`endif

endmodule

`default_nettype wire
